@@ design/mai_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers of the moving-average indicator bank.
// No dependencies; every other file of the block imports this package.
package mai_pkg;

    // Delay line depths; both must be powers of two (pointers wrap by truncation).
    localparam int LONG_DEPTH  = 1024;
    localparam int SHORT_DEPTH = 128;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int MACD_W    = SAMPLE_W + 1;
    localparam int EMA_SHIFT = 16;
    localparam int EMA_P_W   = (SAMPLE_W + 1) + (COEF_W + 1);

    localparam int LONG_AW     = $clog2(LONG_DEPTH);
    localparam int SHORT_AW    = $clog2(SHORT_DEPTH);
    localparam int LONG_WW     = $clog2(LONG_DEPTH + 1);
    localparam int SHORT_WW    = $clog2(SHORT_DEPTH + 1);
    localparam int LONG_SUM_W  = SAMPLE_W + LONG_AW;
    localparam int SHORT_SUM_W = SAMPLE_W + SHORT_AW;

    localparam int DIV_NUM_W = (LONG_SUM_W > SHORT_SUM_W) ? LONG_SUM_W : SHORT_SUM_W;
    localparam int DIV_DEN_W = (LONG_WW > SHORT_WW) ? LONG_WW : SHORT_WW;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int LONG_REG_W   = 11;
    localparam int SHORT_REG_W  = 8;

    localparam int LONG_WIN_RESET  = 1000;
    localparam int SHORT_WIN_RESET = 100;
    localparam int FAST_COEF_RESET = 6554;
    localparam int MID_COEF_RESET  = 5041;
    localparam int SLOW_COEF_RESET = 2427;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_WIN  = 3'd0,
        CFG_SHORT_WIN = 3'd1,
        CFG_FAST_COEF = 3'd2,
        CFG_MID_COEF  = 3'd3,
        CFG_SLOW_COEF = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_back_state;

    typedef struct packed {
        logic [LONG_WW-1:0]  long_win;
        logic [SHORT_WW-1:0] short_win;
        logic [COEF_W-1:0]   fast_coef;
        logic [COEF_W-1:0]   mid_coef;
        logic [COEF_W-1:0]   slow_coef;
        logic                long_restart;
        logic                short_restart;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic [SAMPLE_W-1:0] quot;
    } t_div_rsp;

    // Zero means a window of one; anything above the line depth saturates.
    function automatic logic [LONG_WW-1:0] clamp_long(input logic [LONG_REG_W-1:0] v);
        logic [LONG_WW-1:0] res;
        if (v == '0) begin
            res = LONG_WW'(1);
        end else if (32'(v) > LONG_DEPTH) begin
            res = LONG_WW'(LONG_DEPTH);
        end else begin
            res = LONG_WW'(v);
        end
        return res;
    endfunction

    function automatic logic [SHORT_WW-1:0] clamp_short(input logic [SHORT_REG_W-1:0] v);
        logic [SHORT_WW-1:0] res;
        if (v == '0) begin
            res = SHORT_WW'(1);
        end else if (32'(v) > SHORT_DEPTH) begin
            res = SHORT_WW'(SHORT_DEPTH);
        end else begin
            res = SHORT_WW'(v);
        end
        return res;
    endfunction

endpackage

@@ design/mai_in_if.sv @@
`timescale 1ns / 1ps
// Sample channel of the indicator bank: valid/ready plus one price sample.
// Depends on mai_pkg.
interface mai_in_if import mai_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ design/mai_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the indicator bank: valid/ready plus the indicator fields.
// Depends on mai_pkg.
interface mai_out_if import mai_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [SAMPLE_W-1:0]      long_mean;
    logic                     long_valid;
    logic [SAMPLE_W-1:0]      short_mean;
    logic                     short_valid;
    logic [SAMPLE_W-1:0]      fast_avg;
    logic [SAMPLE_W-1:0]      mid_avg;
    logic [SAMPLE_W-1:0]      slow_avg;
    logic signed [MACD_W-1:0] macd_value;

    modport source (output valid, output long_mean, output long_valid, output short_mean,
                    output short_valid, output fast_avg, output mid_avg, output slow_avg,
                    output macd_value, input ready);
    modport sink   (input valid, input long_mean, input long_valid, input short_mean,
                    input short_valid, input fast_avg, input mid_avg, input slow_avg,
                    input macd_value, output ready);
endinterface

@@ design/mai_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider for the window means, one quotient bit per cycle.
// Depends on mai_pkg (widths, request and response structs).
module mai_div import mai_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = w_shift >= {1'b0, r_den};
        // remainder stays below the divisor, so the top bit drops out
        n_rem   = w_ge ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quo[SAMPLE_W-1:0];

endmodule

@@ design/mai_front.sv @@
`timescale 1ns / 1ps
// Front end: takes sample items off the input channel into a short queue.
// Depends on mai_pkg and mai_in_if; feeds mai_back.
module mai_front import mai_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mai_in_if.sink              s_in,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_sample,
    input  logic                i_pop
);

    logic [SAMPLE_W-1:0] r_data [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign s_in.ready = r_count != QUEUE_CW'(QUEUE_DEPTH);
    assign w_push     = s_in.valid && s_in.ready;
    assign w_pop      = i_pop && (r_count != '0);
    assign o_valid    = r_count != '0;
    assign o_sample   = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= s_in.sample;
        end
    end

endmodule

@@ design/mai_back.sv @@
`timescale 1ns / 1ps
// Back end: window delay lines and sums, three EMAs, the two mean dividers
// and the result register. Depends on mai_pkg, mai_out_if and mai_div.
module mai_back import mai_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_pop,
    mai_out_if.source           m_out
);

    t_back_state r_state;
    t_back_state n_state;

    logic [SAMPLE_W-1:0]    r_long_line  [LONG_DEPTH];
    logic [SAMPLE_W-1:0]    r_short_line [SHORT_DEPTH];
    logic [SAMPLE_W-1:0]    r_long_old;
    logic [SAMPLE_W-1:0]    r_short_old;

    logic [LONG_SUM_W-1:0]  r_long_sum;
    logic [LONG_WW-1:0]     r_long_fill;
    logic [LONG_AW-1:0]     r_long_ptr;
    logic [SHORT_SUM_W-1:0] r_short_sum;
    logic [SHORT_WW-1:0]    r_short_fill;
    logic [SHORT_AW-1:0]    r_short_ptr;
    logic                   r_long_ok;
    logic                   r_short_ok;

    logic [SAMPLE_W-1:0]    r_sample;
    logic [SAMPLE_W-1:0]    r_fast;
    logic [SAMPLE_W-1:0]    r_mid;
    logic [SAMPLE_W-1:0]    r_slow;
    logic [SAMPLE_W-1:0]    r_fast_q;
    logic [SAMPLE_W-1:0]    r_mid_q;
    logic [SAMPLE_W-1:0]    r_slow_q;

    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_out_long;
    logic                   r_out_long_ok;
    logic [SAMPLE_W-1:0]    r_out_short;
    logic                   r_out_short_ok;
    logic [SAMPLE_W-1:0]    r_out_fast;
    logic [SAMPLE_W-1:0]    r_out_mid;
    logic [SAMPLE_W-1:0]    r_out_slow;
    logic [MACD_W-1:0]      r_out_macd;

    logic [LONG_AW-1:0]     w_long_rd;
    logic [SHORT_AW-1:0]    w_short_rd;
    logic                   w_long_full;
    logic                   w_short_full;
    logic [LONG_SUM_W-1:0]  n_long_sum;
    logic [SHORT_SUM_W-1:0] n_short_sum;
    logic [LONG_WW-1:0]     n_long_fill;
    logic [SHORT_WW-1:0]    n_short_fill;

    logic                   w_take;
    logic                   w_update;
    logic                   w_load;
    logic                   w_div_done;

    t_div_req               w_long_req;
    t_div_req               w_short_req;
    t_div_rsp               w_long_rsp;
    t_div_rsp               w_short_rsp;

    // Low bits of floor(coef * (x - prev) / 2^16); added to prev mod 2^16.
    function automatic logic [SAMPLE_W-1:0] ema_term(
        input logic [SAMPLE_W-1:0] x,
        input logic [SAMPLE_W-1:0] prev,
        input logic [COEF_W-1:0]   coef
    );
        logic signed [SAMPLE_W:0]  d;
        logic signed [EMA_P_W-1:0] p;
        d = $signed({1'b0, x}) - $signed({1'b0, prev});
        p = $signed({1'b0, coef}) * d;
        return p[EMA_SHIFT +: SAMPLE_W];
    endfunction

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_take   = 1'b0;
        w_update = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            ST_IDLE: w_take   = i_valid;
            ST_SUM:  w_update = 1'b1;
            ST_DIV:  w_load   = 1'b0;
            ST_OUT:  w_load   = !r_out_valid || m_out.ready;
            default: w_take   = 1'b0;
        endcase
    end

    assign o_pop      = w_take;
    assign w_div_done = !w_long_rsp.busy && !w_short_rsp.busy;

    // Oldest sample of each window; a window equal to the depth wraps to ptr itself.
    assign w_long_rd  = r_long_ptr - i_cfg.long_win[LONG_AW-1:0];
    assign w_short_rd = r_short_ptr - i_cfg.short_win[SHORT_AW-1:0];

    always_comb begin
        w_long_full  = r_long_fill >= i_cfg.long_win;
        w_short_full = r_short_fill >= i_cfg.short_win;
        n_long_sum   = r_long_sum - (w_long_full ? LONG_SUM_W'(r_long_old) : '0)
                       + LONG_SUM_W'(r_sample);
        n_short_sum  = r_short_sum - (w_short_full ? SHORT_SUM_W'(r_short_old) : '0)
                       + SHORT_SUM_W'(r_sample);
        n_long_fill  = w_long_full ? r_long_fill : r_long_fill + 1'b1;
        n_short_fill = w_short_full ? r_short_fill : r_short_fill + 1'b1;
    end

    always_comb begin
        w_long_req.start  = w_update;
        w_long_req.num    = DIV_NUM_W'(n_long_sum);
        w_long_req.den    = DIV_DEN_W'(i_cfg.long_win);
        w_short_req.start = w_update;
        w_short_req.num   = DIV_NUM_W'(n_short_sum);
        w_short_req.den   = DIV_DEN_W'(i_cfg.short_win);
    end

    mai_div u_long_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_long_req),
        .o_rsp   (w_long_rsp)
    );

    mai_div u_short_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_short_req),
        .o_rsp   (w_short_rsp)
    );

    // Delay lines: write the new sample at ptr, read the oldest one every cycle.
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_long_line[r_long_ptr] <= r_sample;
        end
        r_long_old <= r_long_line[w_long_rd];
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_short_line[r_short_ptr] <= r_sample;
        end
        r_short_old <= r_short_line[w_short_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_long_sum   <= '0;
            r_long_fill  <= '0;
            r_long_ptr   <= '0;
            r_short_sum  <= '0;
            r_short_fill <= '0;
            r_short_ptr  <= '0;
            r_fast       <= '0;
            r_mid        <= '0;
            r_slow       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.long_restart) begin
                r_long_sum  <= '0;
                r_long_fill <= '0;
            end else if (w_update) begin
                r_long_sum  <= n_long_sum;
                r_long_fill <= n_long_fill;
            end
            if (i_cfg.short_restart) begin
                r_short_sum  <= '0;
                r_short_fill <= '0;
            end else if (w_update) begin
                r_short_sum  <= n_short_sum;
                r_short_fill <= n_short_fill;
            end
            if (w_update) begin
                r_long_ptr  <= r_long_ptr + 1'b1;
                r_short_ptr <= r_short_ptr + 1'b1;
                r_fast      <= r_fast + r_fast_q;
                r_mid       <= r_mid + r_mid_q;
                r_slow      <= r_slow + r_slow_q;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sample <= i_sample;
            r_fast_q <= ema_term(i_sample, r_fast, i_cfg.fast_coef);
            r_mid_q  <= ema_term(i_sample, r_mid, i_cfg.mid_coef);
            r_slow_q <= ema_term(i_sample, r_slow, i_cfg.slow_coef);
        end
        if (w_update) begin
            r_long_ok  <= n_long_fill >= i_cfg.long_win;
            r_short_ok <= n_short_fill >= i_cfg.short_win;
        end
        if (w_load) begin
            r_out_long     <= r_long_ok ? w_long_rsp.quot : '0;
            r_out_long_ok  <= r_long_ok;
            r_out_short    <= r_short_ok ? w_short_rsp.quot : '0;
            r_out_short_ok <= r_short_ok;
            r_out_fast     <= r_fast;
            r_out_mid      <= r_mid;
            r_out_slow     <= r_slow;
            r_out_macd     <= {1'b0, r_mid} - {1'b0, r_slow};
        end
    end

    assign m_out.valid       = r_out_valid;
    assign m_out.long_mean   = r_out_long;
    assign m_out.long_valid  = r_out_long_ok;
    assign m_out.short_mean  = r_out_short;
    assign m_out.short_valid = r_out_short_ok;
    assign m_out.fast_avg    = r_out_fast;
    assign m_out.mid_avg     = r_out_mid;
    assign m_out.slow_avg    = r_out_slow;
    assign m_out.macd_value  = $signed(r_out_macd);

endmodule

@@ design/moving_average_indicator_bank.sv @@
`timescale 1ns / 1ps
// Moving-average indicator bank: for every unsigned Q0.16 price sample it returns the
// long and short sliding-window means (0 with the valid flag low until the window
// is full), three exponential averages and MACD (middle minus slow). One result per
// sample, in order. For each item the back end takes the sample, updates the windows and
// averages, runs the bit-serial mean dividers (one quotient bit per cycle) until both
// finish, then loads the result register. The load waits while an earlier result is
// still unaccepted. A two-entry input queue keeps accepting while a result waits.
// Writing a window register restarts that window; coefficient writes take effect from
// the next sample. Write registers only while the block is idle.
// Depends on mai_pkg, mai_in_if, mai_out_if, mai_front and mai_back.
module moving_average_indicator_bank import mai_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mai_in_if.sink                i_in,
    mai_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [LONG_WW-1:0]  r_long_win;
    logic [SHORT_WW-1:0] r_short_win;
    logic [COEF_W-1:0]   r_fast_coef;
    logic [COEF_W-1:0]   r_mid_coef;
    logic [COEF_W-1:0]   r_slow_coef;

    logic                w_long_wr;
    logic                w_short_wr;
    t_cfg                w_cfg;

    logic                w_q_valid;
    logic [SAMPLE_W-1:0] w_q_sample;
    logic                w_q_pop;

    assign w_long_wr  = i_cfg_we && (i_cfg_idx == CFG_LONG_WIN);
    assign w_short_wr = i_cfg_we && (i_cfg_idx == CFG_SHORT_WIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_win  <= clamp_long(LONG_REG_W'(LONG_WIN_RESET));
            r_short_win <= clamp_short(SHORT_REG_W'(SHORT_WIN_RESET));
            r_fast_coef <= COEF_W'(FAST_COEF_RESET);
            r_mid_coef  <= COEF_W'(MID_COEF_RESET);
            r_slow_coef <= COEF_W'(SLOW_COEF_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_WIN:  r_long_win  <= clamp_long(i_cfg_data[LONG_REG_W-1:0]);
                CFG_SHORT_WIN: r_short_win <= clamp_short(i_cfg_data[SHORT_REG_W-1:0]);
                CFG_FAST_COEF: r_fast_coef <= i_cfg_data[COEF_W-1:0];
                CFG_MID_COEF:  r_mid_coef  <= i_cfg_data[COEF_W-1:0];
                CFG_SLOW_COEF: r_slow_coef <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg.long_win      = r_long_win;
        w_cfg.short_win     = r_short_win;
        w_cfg.fast_coef     = r_fast_coef;
        w_cfg.mid_coef      = r_mid_coef;
        w_cfg.slow_coef     = r_slow_coef;
        w_cfg.long_restart  = w_long_wr;
        w_cfg.short_restart = w_short_wr;
    end

    mai_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_in     (i_in),
        .o_valid  (w_q_valid),
        .o_sample (w_q_sample),
        .i_pop    (w_q_pop)
    );

    mai_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_q_valid),
        .i_sample (w_q_sample),
        .o_pop    (w_q_pop),
        .m_out    (o_out)
    );

    // The queue only fills up on an accepted item.
    a_ready_falls_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in.ready) |-> $past(i_in.valid))
        else $error("input ready dropped without an accepted item");

    // A mean whose window is not yet full reads as zero.
    a_mean_zero_until_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.long_valid || o_out.long_mean == '0) &&
                         (o_out.short_valid || o_out.short_mean == '0)))
        else $error("mean nonzero while its window is not full");

    a_macd_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.macd_value ==
                         $signed({1'b0, o_out.mid_avg} - {1'b0, o_out.slow_avg})))
        else $error("macd does not match middle minus slow average");

endmodule

@@ tb/sv/moving_average_indicator_bank_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the moving-average indicator bank: a directed table,
// then randomized window and coefficient phases, each result compared with the table or a predictor.
// Depends on mai_pkg, mai_in_if, mai_out_if and moving_average_indicator_bank.
module moving_average_indicator_bank_test;
    import mai_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] long_mean;
        logic                long_valid;
        logic [SAMPLE_W-1:0] short_mean;
        logic                short_valid;
        logic [SAMPLE_W-1:0] fast_avg;
        logic [SAMPLE_W-1:0] mid_avg;
        logic [SAMPLE_W-1:0] slow_avg;
        logic [MACD_W-1:0]   macd_value;
    } t_indicator;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   typed;
        t_indicator             want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mai_in_if  in_if ();
    mai_out_if out_if ();

    moving_average_indicator_bank u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state
    logic [SAMPLE_W-1:0] long_line [LONG_DEPTH];
    logic [SAMPLE_W-1:0] short_line [SHORT_DEPTH];
    int                  long_span, short_span;
    int                  long_sum, short_sum;
    int                  long_fill, short_fill;
    int                  long_ptr, short_ptr;
    logic [COEF_W-1:0]   fast_coef, mid_coef, slow_coef;
    logic [SAMPLE_W-1:0] fast_level, mid_level, slow_level;

    t_indicator pending_results[$];
    t_stim_row  stim_rows[$];

    int mismatch_count = 0;
    int results_checked = 0;
    int long_full_seen = 0;
    int samples_sent = 0;
    int writes_done = 0;
    int random_count = 0;
    int send_idle_pct = 17;
    int recv_idle_pct = 53;
    int idle_cycles = 0;

    function automatic int window_span(input int v, input int depth);
        if (v == 0) return 1;
        if (v > depth) return depth;
        return v;
    endfunction

    // prev + floor(coef * (x - prev) / 2^16), wrapped to 16 bits
    function automatic logic [SAMPLE_W-1:0] ema_next(input logic [SAMPLE_W-1:0] prev,
                                                     input logic [SAMPLE_W-1:0] x,
                                                     input logic [COEF_W-1:0] coef);
        longint d;
        longint p;
        d = longint'(x) - longint'(prev);
        p = longint'(coef) * d;
        return prev + SAMPLE_W'(p >>> EMA_SHIFT);
    endfunction

    function automatic t_indicator advance_indicators(input logic [SAMPLE_W-1:0] x);
        t_indicator r;
        r = '0;
        if (long_fill >= long_span)
            long_sum -= long_line[(long_ptr + LONG_DEPTH - long_span) % LONG_DEPTH];
        long_sum += x;
        long_line[long_ptr] = x;
        long_ptr = (long_ptr + 1) % LONG_DEPTH;
        if (long_fill < long_span) long_fill++;
        if (long_fill >= long_span) begin
            r.long_mean  = SAMPLE_W'(long_sum / long_span);
            r.long_valid = 1'b1;
        end
        if (short_fill >= short_span)
            short_sum -= short_line[(short_ptr + SHORT_DEPTH - short_span) % SHORT_DEPTH];
        short_sum += x;
        short_line[short_ptr] = x;
        short_ptr = (short_ptr + 1) % SHORT_DEPTH;
        if (short_fill < short_span) short_fill++;
        if (short_fill >= short_span) begin
            r.short_mean  = SAMPLE_W'(short_sum / short_span);
            r.short_valid = 1'b1;
        end
        fast_level = ema_next(fast_level, x, fast_coef);
        mid_level  = ema_next(mid_level, x, mid_coef);
        slow_level = ema_next(slow_level, x, slow_coef);
        r.fast_avg   = fast_level;
        r.mid_avg    = mid_level;
        r.slow_avg   = slow_level;
        r.macd_value = {1'b0, mid_level} - {1'b0, slow_level};
        return r;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_LONG_WIN: begin
                long_span = window_span(int'(value[LONG_REG_W-1:0]), LONG_DEPTH);
                long_sum  = 0;
                long_fill = 0;
            end
            CFG_SHORT_WIN: begin
                short_span = window_span(int'(value[SHORT_REG_W-1:0]), SHORT_DEPTH);
                short_sum  = 0;
                short_fill = 0;
            end
            CFG_FAST_COEF: fast_coef = value;
            CFG_MID_COEF:  mid_coef  = value;
            CFG_SLOW_COEF: slow_coef = value;
            default: ;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t, result %0d: %s", $realtime, results_checked, msg);
        mismatch_count++;
    endtask

    // Lower valid and wait until every expected result has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the next sample lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        apply_config(idx, value);
        writes_done++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic typed,
                               input t_indicator want);
        t_indicator pred;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pred = advance_indicators(value);
        pending_results.push_back(typed ? want : pred);
        samples_sent++;
    endtask

    task automatic run_phase(input int n_items, input int long_w, input int short_w);
        logic [SAMPLE_W-1:0] value;
        logic [CFG_DATA_W-1:0] upper;
        drain_results();
        // Random bits above the register width must be dropped by the block.
        upper = CFG_DATA_W'($urandom);
        write_reg(CFG_LONG_WIN, {upper[CFG_DATA_W-1:LONG_REG_W], LONG_REG_W'(long_w)});
        upper = CFG_DATA_W'($urandom);
        write_reg(CFG_SHORT_WIN, {upper[CFG_DATA_W-1:SHORT_REG_W], SHORT_REG_W'(short_w)});
        write_reg(CFG_FAST_COEF, pick_coef());
        write_reg(CFG_MID_COEF, pick_coef());
        write_reg(CFG_SLOW_COEF, pick_coef());
        for (int n = 0; n < n_items; n++) begin
            if (random_count < 533) begin
                send_idle_pct = 17;
                recv_idle_pct = 53;
            end else if (random_count < 1066) begin
                send_idle_pct = 53;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(9) == 0) value = '0;
            else if ($urandom_range(9) == 0) value = '1;
            else value = SAMPLE_W'($urandom);
            send_sample(value, 1'b0, '0);
            random_count++;
        end
    endtask

    // Result side: check each accepted result, then pick ready for the next cycle.
    always @(posedge i_clk) begin : result_check
        t_indicator got;
        t_indicator want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.long_mean, out_if.long_valid, out_if.short_mean,
                        out_if.short_valid, out_if.fast_avg, out_if.mid_avg,
                        out_if.slow_avg, out_if.macd_value};
                if (pending_results.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (got.long_mean !== want.long_mean)
                        report_mismatch($sformatf("long_mean got %0d want %0d",
                                                  got.long_mean, want.long_mean));
                    if (got.long_valid !== want.long_valid)
                        report_mismatch($sformatf("long_valid got %0b want %0b",
                                                  got.long_valid, want.long_valid));
                    if (got.short_mean !== want.short_mean)
                        report_mismatch($sformatf("short_mean got %0d want %0d",
                                                  got.short_mean, want.short_mean));
                    if (got.short_valid !== want.short_valid)
                        report_mismatch($sformatf("short_valid got %0b want %0b",
                                                  got.short_valid, want.short_valid));
                    if (got.fast_avg !== want.fast_avg)
                        report_mismatch($sformatf("fast_avg got %0d want %0d",
                                                  got.fast_avg, want.fast_avg));
                    if (got.mid_avg !== want.mid_avg)
                        report_mismatch($sformatf("mid_avg got %0d want %0d",
                                                  got.mid_avg, want.mid_avg));
                    if (got.slow_avg !== want.slow_avg)
                        report_mismatch($sformatf("slow_avg got %0d want %0d",
                                                  got.slow_avg, want.slow_avg));
                    if (got.macd_value !== want.macd_value)
                        report_mismatch($sformatf("macd_value got %0h want %0h",
                                                  got.macd_value, want.macd_value));
                    if (want.long_valid) long_full_seen++;
                end
                results_checked++;
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_stim_row row;
        logic      last_was_sample;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_LONG_WIN;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;

        long_span  = window_span(LONG_WIN_RESET, LONG_DEPTH);
        short_span = window_span(SHORT_WIN_RESET, SHORT_DEPTH);
        long_sum   = 0;
        short_sum  = 0;
        long_fill  = 0;
        short_fill = 0;
        long_ptr   = 0;
        short_ptr  = 0;
        fast_coef  = FAST_COEF_RESET;
        mid_coef   = MID_COEF_RESET;
        slow_coef  = SLOW_COEF_RESET;
        fast_level = '0;
        mid_level  = '0;
        slow_level = '0;

        // Reset state and a full-scale step under the reset coefficients.
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'd0, 1'b1, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'hFFFF, 1'b1,
                              '{16'd0, 1'b0, 16'd0, 1'b0, 16'd6553, 16'd5040, 16'd2426,
                                17'd2614}});
        // Zero windows act as one sample; coefficient extremes.
        stim_rows.push_back('{ROW_WRITE, CFG_LONG_WIN, 16'd0, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SHORT_WIN, 16'd0, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_FAST_COEF, 16'd0, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_MID_COEF, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SLOW_COEF, 16'd1, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'd0, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'hFFFF, 1'b0, '0});
        // Unused register indexes are ignored.
        stim_rows.push_back('{ROW_WRITE, CFG_UNUSED_FIRST, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_UNUSED_LAST, 16'h0001, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'd12345, 1'b0, '0});
        // Windows above the line depth saturate.
        stim_rows.push_back('{ROW_WRITE, CFG_LONG_WIN, 16'd2047, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SHORT_WIN, 16'd255, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'd0, 1'b0, '0});
        // Small windows restart mid-stream and fill quickly.
        stim_rows.push_back('{ROW_WRITE, CFG_LONG_WIN, 16'd3, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SHORT_WIN, 16'd2, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_FAST_COEF, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SLOW_COEF, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'd1, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'd32768, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, CFG_LONG_WIN, 16'hFFFF, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        last_was_sample = 1'b0;
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_WRITE) begin
                if (last_was_sample) drain_results();
                write_reg(row.idx, row.value);
                last_was_sample = 1'b0;
            end else begin
                send_sample(row.value, row.typed, row.want);
                last_was_sample = 1'b1;
            end
        end

        run_phase(200, $urandom_range(1, 40), $urandom_range(1, 16));
        run_phase(1080, $urandom_range(1) ? LONG_DEPTH : $urandom_range(1025, 2047),
                  $urandom_range(64, 255));
        repeat (4) run_phase(80, $urandom_range(0, 100), $urandom_range(0, 255));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("Checked %0d results from %0d samples with %0d register writes",
                 results_checked, samples_sent, writes_done);
        $display("Long window was full for %0d of those results", long_full_seen);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
